// ===== sv/mrpt_pkg.sv =====
// ============================================================================
// mrpt_pkg: shared types and constants
// Widths, witness base tables and sequencer states for the primality tester.
// ============================================================================
package mrpt_pkg;

  localparam int NUM_WIDTH = 63;
  localparam int CNT_WIDTH = 6;
  localparam int BASE_IDX_WIDTH = 3;
  localparam int NUM_SMALL_BASES = 3;
  localparam int NUM_LARGE_BASES = 7;
  localparam logic [NUM_WIDTH-1:0] SMALL_LIMIT = NUM_WIDTH'(64'd2147483647);

  typedef logic [NUM_WIDTH-1:0] num_t;

  // Modular multiplier control.
  typedef struct packed {
    logic start;
    num_t a;
    num_t b;
    num_t m;
  } mm_req_t;

  typedef struct packed {
    logic done;
    num_t prod;
  } mm_rsp_t;

  function automatic num_t base_value(input logic big_set,
                                      input logic [BASE_IDX_WIDTH-1:0] idx);
    logic [31:0] v;
    v = 32'd0;
    if (!big_set) begin
      unique case (idx)
        3'd0: v = 32'd2;
        3'd1: v = 32'd7;
        3'd2: v = 32'd61;
        default: v = 32'd0;
      endcase
    end else begin
      unique case (idx)
        3'd0: v = 32'd2;
        3'd1: v = 32'd325;
        3'd2: v = 32'd9375;
        3'd3: v = 32'd28178;
        3'd4: v = 32'd450775;
        3'd5: v = 32'd9780504;
        3'd6: v = 32'd1795265022;
        default: v = 32'd0;
      endcase
    end
    return NUM_WIDTH'(v);
  endfunction

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_BASE   = 11'b00000000010,
    ST_RED    = 11'b00000000100,
    ST_PSTEP  = 11'b00000001000,
    ST_PMUL   = 11'b00000010000,
    ST_PSQR   = 11'b00000100000,
    ST_CHK    = 11'b00001000000,
    ST_SQ     = 11'b00010000000,
    ST_SQCHK  = 11'b00100000000,
    ST_NEXT   = 11'b01000000000,
    ST_OUT    = 11'b10000000000
  } state_t;

endpackage

// ===== sv/mrpt_modmul.sv =====
// ============================================================================
// mrpt_modmul: shift-and-add modular multiplier
// Computes a*b mod m one bit of b per cycle, for a, b < m.
// ============================================================================
module mrpt_modmul
  import mrpt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  mm_req_t req,
  output mm_rsp_t rsp
);

  num_t a_r, a_nxt, b_r, b_nxt, m_r, acc_r, acc_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [NUM_WIDTH:0] sum_acc, sum_dbl;

  always_comb begin
    sum_acc = {1'b0, acc_r} + {1'b0, a_r};
    sum_dbl = {1'b0, a_r} + {1'b0, a_r};
    acc_nxt = acc_r;
    a_nxt = a_r;
    b_nxt = b_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt = '0;
      a_nxt = req.a;
      b_nxt = req.b;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (b_r[0]) begin
          acc_nxt = (sum_acc >= {1'b0, m_r}) ? NUM_WIDTH'(sum_acc - {1'b0, m_r})
                                            : NUM_WIDTH'(sum_acc);
        end
        a_nxt = (sum_dbl >= {1'b0, m_r}) ? NUM_WIDTH'(sum_dbl - {1'b0, m_r})
                                        : NUM_WIDTH'(sum_dbl);
        b_nxt = b_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    if (req.start) m_r <= req.m;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

  property p_done_after_busy;
    @(posedge clk) disable iff (!rst_n) done_r |-> !busy_r;
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("done while busy");

  property p_acc_below_mod;
    @(posedge clk) disable iff (!rst_n) done_r |-> (acc_r < m_r);
  endproperty
  a_acc_below_mod: assert property (p_acc_below_mod) else $error("product not reduced");

  property p_start_busy;
    @(posedge clk) disable iff (!rst_n) req.start |=> busy_r;
  endproperty
  a_start_busy: assert property (p_start_busy) else $error("start did not arm");

endmodule

// ===== sv/miller_rabin_prime_test_64_unit.sv =====
// ============================================================================
// miller_rabin_prime_test_64_unit: deterministic 63-bit primality tester
// Runs strong-probable-prime tests with fixed witness sets on one candidate.
// ============================================================================
// One candidate beat is taken, tested, and one is_prime beat is returned. Values
// below 2 and even values are decided in the idle state without a base test. Odd
// values up to 2^31-1 are tested against bases 2, 7 and 61, larger ones against
// seven bases. All modular products go through one shift-and-add modular
// multiplier; a test ends as soon as one base shows the candidate composite.
// The block is not ready while a candidate is in work or while its result
// waits to be taken.
module miller_rabin_prime_test_64_unit
  import mrpt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [NUM_WIDTH-1:0] in_number,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_is_prime
);

  state_t state_r, state_nxt;
  num_t n_r, n_nxt, d_r, d_nxt, e_r, e_nxt, x_r, x_nxt, b_r, b_nxt;
  logic [CNT_WIDTH-1:0] s_r, s_nxt, i_r, i_nxt;
  logic [BASE_IDX_WIDTH-1:0] bidx_r, bidx_nxt;
  logic large_r, large_nxt, res_r, res_nxt;
  num_t nm1, base_raw, base_red;
  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  mrpt_modmul u_modmul (.clk(clk), .rst_n(rst_n), .req(mm_req), .rsp(mm_rsp));

  assign nm1 = n_r - NUM_WIDTH'(1);
  assign base_raw = base_value(large_r, bidx_r);
  // All bases are below 2^31, so a base can exceed n only when n is small;
  // such a base is reduced by repeated subtraction below.
  assign base_red = base_raw;

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_is_prime = res_r;

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; d_nxt = d_r; e_nxt = e_r; x_nxt = x_r; b_nxt = b_r;
    s_nxt = s_r; i_nxt = i_r; bidx_nxt = bidx_r;
    large_nxt = large_r; res_nxt = res_r;
    mm_req.start = 1'b0;
    mm_req.a = x_r;
    mm_req.b = x_r;
    mm_req.m = n_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt = in_number;
          large_nxt = (in_number > SMALL_LIMIT);
          bidx_nxt = '0;
          res_nxt = 1'b1;
          if (in_number < NUM_WIDTH'(2)) begin
            res_nxt = 1'b0; state_nxt = ST_OUT;
          end else if (!in_number[0]) begin
            res_nxt = (in_number == NUM_WIDTH'(2)); state_nxt = ST_OUT;
          end else begin
            d_nxt = in_number - NUM_WIDTH'(1);
            s_nxt = '0;
            state_nxt = ST_BASE;
          end
        end
      end
      ST_BASE: begin
        // Strip trailing zeros of n-1 one bit per cycle (only first base).
        if (!d_r[0]) begin
          d_nxt = d_r >> 1;
          s_nxt = s_r + CNT_WIDTH'(1);
        end else begin
          b_nxt = base_red;
          state_nxt = ST_RED;
        end
      end
      ST_RED: begin
        if (b_r >= n_r) b_nxt = b_r - n_r;
        else if (b_r == '0) state_nxt = ST_NEXT;
        else begin
          x_nxt = NUM_WIDTH'(1);
          e_nxt = d_r;
          state_nxt = ST_PSTEP;
        end
      end
      ST_PSTEP: begin
        if (e_r == '0) state_nxt = ST_CHK;
        else if (e_r[0]) begin
          mm_req.start = 1'b1; mm_req.a = x_r; mm_req.b = b_r;
          state_nxt = ST_PMUL;
        end else begin
          mm_req.start = 1'b1; mm_req.a = b_r; mm_req.b = b_r;
          state_nxt = ST_PSQR;
        end
      end
      ST_PMUL: begin
        if (mm_rsp.done) begin
          x_nxt = mm_rsp.prod;
          mm_req.start = 1'b1; mm_req.a = b_r; mm_req.b = b_r;
          state_nxt = ST_PSQR;
        end
      end
      ST_PSQR: begin
        if (mm_rsp.done) begin
          b_nxt = mm_rsp.prod;
          e_nxt = e_r >> 1;
          state_nxt = ST_PSTEP;
        end
      end
      ST_CHK: begin
        i_nxt = CNT_WIDTH'(1);
        if (x_r == NUM_WIDTH'(1) || x_r == nm1) state_nxt = ST_NEXT;
        else state_nxt = ST_SQCHK;
      end
      ST_SQCHK: begin
        if (i_r >= s_r) begin
          res_nxt = 1'b0; state_nxt = ST_OUT;
        end else begin
          mm_req.start = 1'b1; mm_req.a = x_r; mm_req.b = x_r;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (mm_rsp.done) begin
          x_nxt = mm_rsp.prod;
          i_nxt = i_r + CNT_WIDTH'(1);
          if (mm_rsp.prod == nm1) state_nxt = ST_NEXT;
          else state_nxt = ST_SQCHK;
        end
      end
      ST_NEXT: begin
        if ((!large_r && bidx_r == BASE_IDX_WIDTH'(NUM_SMALL_BASES - 1)) ||
            (large_r && bidx_r == BASE_IDX_WIDTH'(NUM_LARGE_BASES - 1))) begin
          state_nxt = ST_OUT;
        end else begin
          bidx_nxt = bidx_r + BASE_IDX_WIDTH'(1);
          state_nxt = ST_BASE;
        end
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    n_r <= n_nxt; d_r <= d_nxt; e_r <= e_nxt; x_r <= x_nxt; b_r <= b_nxt;
    s_r <= s_nxt; i_r <= i_nxt; bidx_r <= bidx_nxt;
    large_r <= large_nxt; res_r <= res_nxt;
  end

  property p_onehot;
    @(posedge clk) disable iff (!rst_n) $onehot(state_r);
  endproperty
  a_onehot: assert property (p_onehot) else $error("state not one-hot");

  property p_odd_in_test;
    @(posedge clk) disable iff (!rst_n) (state_r == ST_PSTEP) |-> n_r[0];
  endproperty
  a_odd_in_test: assert property (p_odd_in_test) else $error("even modulus in test");

  property p_wait_only_in_mul;
    @(posedge clk) disable iff (!rst_n)
      mm_rsp.done |-> (state_r == ST_PMUL || state_r == ST_PSQR || state_r == ST_SQ);
  endproperty
  a_wait_only_in_mul: assert property (p_wait_only_in_mul) else $error("stray product");

endmodule
